// File: hw/rtl/sct_pkg.sv
package sct_pkg;

    localparam int LENGTH_BITS = 8;
    localparam int VALUE_BITS  = 64;
    localparam int WIDE_BITS   = VALUE_BITS + 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int KW_COUNT    = 5;
    localparam int KW_MAX      = 5;

    typedef logic [LENGTH_BITS-1:0] length_t;
    typedef logic [VALUE_BITS-1:0]  value_t;
    typedef logic [WIDE_BITS-1:0]   wide_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } char_item_t;

    typedef struct packed {
        logic [4:0]                   token_kind;
        logic [2:0]                   error_code;
        logic signed [VALUE_BITS-1:0] number_value;
        logic [LENGTH_BITS-1:0]       token_length;
        logic                         last_of_item;
    } token_item_t;

    // token as held in the queue; the last-of-item flag is added on the way out
    typedef struct packed {
        logic [4:0]                   token_kind;
        logic [2:0]                   error_code;
        logic signed [VALUE_BITS-1:0] number_value;
        logic [LENGTH_BITS-1:0]       token_length;
    } token_t;

    // all tokens caused by one character: one or two
    typedef struct packed {
        logic   two;
        token_t first;
        token_t second;
    } pair_t;

    localparam logic [4:0] KIND_EOF     = 5'd0;
    localparam logic [4:0] KIND_NUMBER  = 5'd1;
    localparam logic [4:0] KIND_IDENT   = 5'd2;
    localparam logic [4:0] KIND_INT     = 5'd3;
    localparam logic [4:0] KIND_PLUS    = 5'd8;
    localparam logic [4:0] KIND_MINUS   = 5'd9;
    localparam logic [4:0] KIND_STAR    = 5'd10;
    localparam logic [4:0] KIND_SLASH   = 5'd11;
    localparam logic [4:0] KIND_PERCENT = 5'd12;
    localparam logic [4:0] KIND_ASSIGN  = 5'd13;
    localparam logic [4:0] KIND_EQ      = 5'd14;
    localparam logic [4:0] KIND_NE      = 5'd15;
    localparam logic [4:0] KIND_NOT     = 5'd16;
    localparam logic [4:0] KIND_LT      = 5'd17;
    localparam logic [4:0] KIND_LE      = 5'd18;
    localparam logic [4:0] KIND_GT      = 5'd19;
    localparam logic [4:0] KIND_GE      = 5'd20;
    localparam logic [4:0] KIND_AND     = 5'd21;
    localparam logic [4:0] KIND_OR      = 5'd22;
    localparam logic [4:0] KIND_SEMI    = 5'd23;
    localparam logic [4:0] KIND_LPAREN  = 5'd24;
    localparam logic [4:0] KIND_RPAREN  = 5'd25;
    localparam logic [4:0] KIND_LBRACE  = 5'd26;
    localparam logic [4:0] KIND_RBRACE  = 5'd27;
    localparam logic [4:0] KIND_COMMA   = 5'd28;
    localparam logic [4:0] KIND_BRACKET = 5'd29;
    localparam logic [4:0] KIND_ERROR   = 5'd30;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_CHAR  = 3'd1;
    localparam logic [2:0] ERR_AMP   = 3'd2;
    localparam logic [2:0] ERR_BAR   = 3'd3;
    localparam logic [2:0] ERR_RANGE = 3'd4;

    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_BANG     = 8'h21;
    localparam logic [7:0] CH_PERCENT  = 8'h25;
    localparam logic [7:0] CH_AMP      = 8'h26;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_0        = 8'h30;
    localparam logic [7:0] CH_9        = 8'h39;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_LESS     = 8'h3C;
    localparam logic [7:0] CH_EQUAL    = 8'h3D;
    localparam logic [7:0] CH_GREATER  = 8'h3E;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_UNDER    = 8'h5F;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_BAR      = 8'h7C;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;

    // int, if, else, while, print
    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX] = '{
        '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00},
        '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00},
        '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00},
        '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65},
        '{8'h70, 8'h72, 8'h69, 8'h6E, 8'h74}
    };
    localparam length_t KW_LEN [KW_COUNT] = '{
        length_t'(3), length_t'(2), length_t'(4), length_t'(5), length_t'(5)
    };

    function automatic length_t sat_inc(length_t v);
        return (v == '1) ? v : v + length_t'(1);
    endfunction

endpackage

// File: hw/rtl/sct_front.sv
module sct_front
    import sct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  char_item_t item,
    output logic       push,
    output pair_t      push_data
);

    typedef enum logic [3:0] {
        S_START, S_NUM, S_IDENT, S_MINUS, S_SLASH, S_EQ, S_NOT,
        S_LT, S_GT, S_AND, S_OR, S_LINE, S_BLOCK, S_BRACKET
    } state_t;

    state_t  state_reg, state_next;
    value_t  mag_reg, mag_next;
    logic    neg_reg, neg_next;
    logic    ovf_reg, ovf_next;
    length_t len_reg, len_next;
    logic [KW_COUNT-1:0] kw_reg, kw_next;
    logic    star_reg, star_next;

    logic [7:0] c;
    logic       is_dig, is_wrd, is_ws;

    // digit accumulate
    value_t  m_base;
    logic    neg_base, ovf_base;
    length_t len_dbase;
    wide_t   ten_m, lim;
    logic    dig_ovf;
    value_t  dig_mag;
    length_t dig_len;

    // identifier / keyword tracking
    length_t l_len;
    logic [KW_COUNT-1:0] l_kw, kw_new;
    length_t let_len;

    token_t  flush_tok, start_tok;
    logic    flush_v, start_v;
    state_t  start_state;

    logic [7:0] pair_char;
    logic [4:0] pair_kind;

    assign c      = item.char_code;
    assign is_dig = (c >= CH_0) && (c <= CH_9);
    assign is_wrd = is_dig || (c == CH_UNDER)
                 || ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z))
                 || ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
    assign is_ws  = (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB) || (c == CH_CR);

    // 10*m + d against the signed limit; m never exceeds the limit so the wide sum cannot wrap
    always_comb
    begin
        m_base    = '0;
        neg_base  = 1'b0;
        ovf_base  = 1'b0;
        len_dbase = '0;
        if (state_reg == S_NUM)
        begin
            m_base    = mag_reg;
            neg_base  = neg_reg;
            ovf_base  = ovf_reg;
            len_dbase = len_reg;
        end
        else if (state_reg == S_MINUS)
        begin
            neg_base  = 1'b1;
            len_dbase = len_reg;
        end
        ten_m   = (wide_t'(m_base) << 3) + (wide_t'(m_base) << 1) + wide_t'(c[3:0]);
        lim     = (wide_t'(1) << (VALUE_BITS - 1)) - wide_t'(!neg_base);
        dig_ovf = ovf_base || (ten_m > lim);
        dig_mag = dig_ovf ? m_base : ten_m[VALUE_BITS-1:0];
        dig_len = sat_inc(len_dbase);
    end

    always_comb
    begin
        l_len = (state_reg == S_IDENT) ? len_reg : '0;
        l_kw  = (state_reg == S_IDENT) ? kw_reg : '1;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            kw_new[i] = l_kw[i] && (l_len < KW_LEN[i]) && (KW_TEXT[i][l_len[2:0]] == c);
        end
        let_len = sat_inc(l_len);
    end

    // token left pending by the current state
    always_comb
    begin
        flush_tok = '0;
        flush_tok.token_length = length_t'(1);
        flush_v   = 1'b1;
        unique case (state_reg)
            S_NUM:
            begin
                flush_tok.token_length = len_reg;
                if (ovf_reg)
                begin
                    flush_tok.token_kind = KIND_ERROR;
                    flush_tok.error_code = ERR_RANGE;
                end
                else
                begin
                    flush_tok.token_kind   = KIND_NUMBER;
                    flush_tok.number_value = neg_reg ? (value_t'(0) - mag_reg) : mag_reg;
                end
            end
            S_IDENT:
            begin
                flush_tok.token_length = len_reg;
                flush_tok.token_kind   = KIND_IDENT;
                for (int i = 0; i < KW_COUNT; i++)
                begin
                    if (kw_reg[i] && (len_reg == KW_LEN[i]))
                        flush_tok.token_kind = KIND_INT + 5'(i);
                end
            end
            S_MINUS: flush_tok.token_kind = KIND_MINUS;
            S_SLASH: flush_tok.token_kind = KIND_SLASH;
            S_EQ:    flush_tok.token_kind = KIND_ASSIGN;
            S_NOT:   flush_tok.token_kind = KIND_NOT;
            S_LT:    flush_tok.token_kind = KIND_LT;
            S_GT:    flush_tok.token_kind = KIND_GT;
            S_AND:
            begin
                flush_tok.token_kind = KIND_ERROR;
                flush_tok.error_code = ERR_AMP;
            end
            S_OR:
            begin
                flush_tok.token_kind = KIND_ERROR;
                flush_tok.error_code = ERR_BAR;
            end
            S_BRACKET:
            begin
                flush_tok.token_kind   = KIND_BRACKET;
                flush_tok.token_length = len_reg;
            end
            default: flush_v = 1'b0;
        endcase
    end

    // classification of a character seen from the start state
    always_comb
    begin
        start_tok = '0;
        start_tok.token_length = length_t'(1);
        start_v     = 1'b0;
        start_state = S_START;
        if (is_dig)
            start_state = S_NUM;
        else if (is_wrd)
            start_state = S_IDENT;
        else if (!is_ws)
        begin
            unique case (c)
                CH_PLUS:     begin start_v = 1'b1; start_tok.token_kind = KIND_PLUS;    end
                CH_STAR:     begin start_v = 1'b1; start_tok.token_kind = KIND_STAR;    end
                CH_PERCENT:  begin start_v = 1'b1; start_tok.token_kind = KIND_PERCENT; end
                CH_SEMI:     begin start_v = 1'b1; start_tok.token_kind = KIND_SEMI;    end
                CH_LPAREN:   begin start_v = 1'b1; start_tok.token_kind = KIND_LPAREN;  end
                CH_RPAREN:   begin start_v = 1'b1; start_tok.token_kind = KIND_RPAREN;  end
                CH_LBRACE:   begin start_v = 1'b1; start_tok.token_kind = KIND_LBRACE;  end
                CH_RBRACE:   begin start_v = 1'b1; start_tok.token_kind = KIND_RBRACE;  end
                CH_COMMA:    begin start_v = 1'b1; start_tok.token_kind = KIND_COMMA;   end
                CH_MINUS:    start_state = S_MINUS;
                CH_SLASH:    start_state = S_SLASH;
                CH_EQUAL:    start_state = S_EQ;
                CH_BANG:     start_state = S_NOT;
                CH_LESS:     start_state = S_LT;
                CH_GREATER:  start_state = S_GT;
                CH_AMP:      start_state = S_AND;
                CH_BAR:      start_state = S_OR;
                CH_LBRACKET: start_state = S_BRACKET;
                default:
                begin
                    start_v = 1'b1;
                    start_tok.token_kind = KIND_ERROR;
                    start_tok.error_code = ERR_CHAR;
                end
            endcase
        end
    end

    always_comb
    begin
        pair_char = CH_EQUAL;
        pair_kind = KIND_EQ;
        unique case (state_reg)
            S_NOT:   pair_kind = KIND_NE;
            S_LT:    pair_kind = KIND_LE;
            S_GT:    pair_kind = KIND_GE;
            S_AND:
            begin
                pair_char = CH_AMP;
                pair_kind = KIND_AND;
            end
            S_OR:
            begin
                pair_char = CH_BAR;
                pair_kind = KIND_OR;
            end
            default: pair_kind = KIND_EQ;
        endcase
    end

    always_comb
    begin
        logic   do_restart;
        token_t eof_tok;
        token_t one_tok;

        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        len_next   = len_reg;
        kw_next    = kw_reg;
        star_next  = star_reg;
        push       = 1'b0;
        push_data  = '0;
        do_restart = 1'b0;
        eof_tok    = '0;
        one_tok    = '0;

        if (accept && item.end_of_input)
        begin
            push = 1'b1;
            if (flush_v)
            begin
                push_data.two    = 1'b1;
                push_data.first  = flush_tok;
                push_data.second = eof_tok;
            end
            else
                push_data.first = eof_tok;
            state_next = S_START;
            mag_next   = '0;
            neg_next   = 1'b0;
            ovf_next   = 1'b0;
            len_next   = '0;
            kw_next    = '1;
            star_next  = 1'b0;
        end
        else if (accept)
        begin
            unique case (state_reg)
                S_NUM:
                begin
                    if (is_dig)
                    begin
                        mag_next = dig_mag;
                        ovf_next = dig_ovf;
                        len_next = dig_len;
                    end
                    else
                        do_restart = 1'b1;
                end
                S_IDENT:
                begin
                    if (is_wrd)
                    begin
                        kw_next  = kw_new;
                        len_next = let_len;
                    end
                    else
                        do_restart = 1'b1;
                end
                S_MINUS:
                begin
                    if (is_dig)
                    begin
                        state_next = S_NUM;
                        neg_next   = 1'b1;
                        mag_next   = dig_mag;
                        ovf_next   = dig_ovf;
                        len_next   = dig_len;
                    end
                    else
                        do_restart = 1'b1;
                end
                S_SLASH:
                begin
                    if (c == CH_SLASH)
                        state_next = S_LINE;
                    else if (c == CH_STAR)
                    begin
                        state_next = S_BLOCK;
                        star_next  = 1'b0;
                    end
                    else
                        do_restart = 1'b1;
                end
                S_EQ, S_NOT, S_LT, S_GT, S_AND, S_OR:
                begin
                    if (c == pair_char)
                    begin
                        one_tok.token_kind   = pair_kind;
                        one_tok.token_length = length_t'(2);
                        push            = 1'b1;
                        push_data.first = one_tok;
                        state_next      = S_START;
                    end
                    else
                        do_restart = 1'b1;
                end
                S_LINE:
                begin
                    if (c == CH_LF)
                        state_next = S_START;
                end
                S_BLOCK:
                begin
                    if (star_reg && (c == CH_SLASH))
                    begin
                        state_next = S_START;
                        star_next  = 1'b0;
                    end
                    else
                        star_next = (c == CH_STAR);
                end
                S_BRACKET:
                begin
                    len_next = sat_inc(len_reg);
                    if (c == CH_RBRACKET)
                    begin
                        one_tok.token_kind   = KIND_BRACKET;
                        one_tok.token_length = sat_inc(len_reg);
                        push            = 1'b1;
                        push_data.first = one_tok;
                        state_next      = S_START;
                    end
                end
                default: do_restart = 1'b1;
            endcase

            // pending token goes out first, then the character starts afresh
            if (do_restart)
            begin
                if (flush_v)
                begin
                    push             = 1'b1;
                    push_data.first  = flush_tok;
                    push_data.two    = start_v;
                    push_data.second = start_tok;
                end
                else
                begin
                    push            = start_v;
                    push_data.first = start_tok;
                end
                state_next = start_state;
                if (is_dig)
                begin
                    mag_next = dig_mag;
                    neg_next = 1'b0;
                    ovf_next = dig_ovf;
                    len_next = dig_len;
                    kw_next  = '1;
                end
                else if (is_wrd)
                begin
                    mag_next = '0;
                    neg_next = 1'b0;
                    ovf_next = 1'b0;
                    len_next = let_len;
                    kw_next  = kw_new;
                end
                else if (!is_ws)
                begin
                    mag_next = '0;
                    neg_next = 1'b0;
                    ovf_next = 1'b0;
                    len_next = length_t'(1);
                    kw_next  = '1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_START;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            len_reg   <= '0;
            kw_reg    <= '1;
            star_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            ovf_reg   <= ovf_next;
            len_reg   <= len_next;
            kw_reg    <= kw_next;
            star_reg  <= star_next;
        end
    end

endmodule

// File: hw/rtl/sct_queue.sv
module sct_queue
    import sct_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  pair_t push_data,
    output logic  full,
    input  logic  pop,
    output pair_t head,
    output logic  empty
);

    pair_t                entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]    count_reg, count_next;

    assign full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/sct_back.sv
module sct_back
    import sct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pair_t       head,
    input  logic        empty,
    output logic        pop,
    output logic        valid,
    input  logic        stall,
    output token_item_t item
);

    logic        valid_reg, valid_next;
    token_item_t item_reg, item_next;
    logic        second_reg, second_next;
    token_t      hold_reg, hold_next;
    logic        load;

    assign load  = !valid_reg || !stall;
    assign pop   = load && !second_reg && !empty;
    assign valid = valid_reg;
    assign item  = item_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        item_next   = item_reg;
        second_next = second_reg;
        hold_next   = hold_reg;
        if (load)
        begin
            if (second_reg)
            begin
                valid_next  = 1'b1;
                item_next   = '{hold_reg.token_kind, hold_reg.error_code,
                                hold_reg.number_value, hold_reg.token_length, 1'b1};
                second_next = 1'b0;
            end
            else if (!empty)
            begin
                valid_next  = 1'b1;
                item_next   = '{head.first.token_kind, head.first.error_code,
                                head.first.number_value, head.first.token_length, !head.two};
                second_next = head.two;
                hold_next   = head.second;
            end
            else
                valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        hold_reg <= hold_next;
    end

endmodule

// File: hw/rtl/source_code_tokenizer.sv
// Lexer for a small C-like language, one source byte per beat.
// Character channel: char_valid / char_stall / char_item. A beat carries a byte,
// or the end-of-input mark, which flushes any pending token and adds an eof token.
// Token channel: token_valid / token_stall / token_item. A character yields zero,
// one or two tokens; last_of_item marks the final token of a character.
// Tokens enter the queue as their byte is taken and leave via the output register.
// Throughput: one byte per cycle while the queue has room; scanner update and the
// 10*m+d accumulate are combinational. The token port moves one token per cycle
// unless stalled, so a character that ends one token and starts another sends two in turn.
// A four-entry queue of per-character results sits between scanner and
// output register; char_stall rises only when that queue is full.
// Stall on the token side holds the output register; the scanner keeps taking
// bytes until the queue fills.
// Reset (rst_n low, asynchronous) returns the scanner to its start state and
// empties the queue and output register; no clearing pass is needed.
module source_code_tokenizer
    import sct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_stall,
    input  char_item_t  char_item,
    output logic        token_valid,
    input  logic        token_stall,
    output token_item_t token_item
);

    logic  accept;
    logic  push, full, pop, empty;
    pair_t push_data, head;

    assign char_stall = full;
    assign accept     = char_valid && !full;

    sct_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (char_item),
        .push      (push),
        .push_data (push_data)
    );

    sct_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    sct_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (empty),
        .pop   (pop),
        .valid (token_valid),
        .stall (token_stall),
        .item  (token_item)
    );

endmodule

// File: hw/rtl/sct_checker.sv
module sct_checker
    import sct_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        char_valid,
    input logic        char_stall,
    input char_item_t  char_item,
    input logic        token_valid,
    input logic        token_stall,
    input token_item_t token_item
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> char_valid && $stable(char_item))
        else $error("character beat changed while stalled");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_stall |=> token_valid && $stable(token_item))
        else $error("token beat changed while stalled");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (token_item.token_kind != KIND_ERROR)
        |-> token_item.error_code == ERR_NONE)
        else $error("error code on a non-error token");

    a_value: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (token_item.token_kind != KIND_NUMBER)
        |-> token_item.number_value == '0)
        else $error("value on a non-number token");

    a_eof: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (token_item.token_kind == KIND_EOF)
        |-> (token_item.token_length == '0) && token_item.last_of_item)
        else $error("eof token malformed");

endmodule

bind source_code_tokenizer sct_checker u_sct_checker (.*);

// File: bench/tokenizer_checker.sv
module tokenizer_checker
    import sct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    input  logic        char_stall,
    input  char_item_t  char_item,
    input  logic        token_valid,
    input  logic        token_stall,
    input  token_item_t token_item,
    output int          fail_count,
    output int          tokens_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        SC_START, SC_NUM, SC_IDENT, SC_MINUS, SC_SLASH, SC_EQ, SC_NOT,
        SC_LT, SC_GT, SC_AND, SC_OR, SC_LINE, SC_BLOCK, SC_BRACKET
    } scan_t;

    scan_t               scan;
    value_t              magnitude;
    logic                negative;
    logic                overflow;
    logic                star_seen;
    length_t             text_len;
    logic [KW_COUNT-1:0] kw_live;

    token_t      char_tokens [$];
    token_item_t expected_tokens [$];

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit is_word(logic [7:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            || c == CH_UNDER || is_digit(c);
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] token mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic emit(logic [4:0] kind, logic [2:0] err, value_t val, length_t len);
        token_t t;
        t.token_kind   = kind;
        t.error_code   = err;
        t.number_value = val;
        t.token_length = len;
        char_tokens.push_back(t);
    endtask

    task automatic clear_scanner();
        scan      = SC_START;
        magnitude = '0;
        negative  = 1'b0;
        overflow  = 1'b0;
        star_seen = 1'b0;
        text_len  = '0;
        kw_live   = '1;
    endtask

    task automatic open_token(scan_t st);
        scan      = st;
        text_len  = length_t'(1);
        magnitude = '0;
        negative  = 1'b0;
        overflow  = 1'b0;
        kw_live   = '1;
    endtask

    task automatic bump_length();
        if (text_len != '1)
            text_len++;
    endtask

    task automatic add_digit(logic [7:0] c);
        value_t d;
        value_t limit;
        d = value_t'(c - CH_0);
        // one more magnitude is allowed for a negative literal
        limit = (value_t'(1) << (VALUE_BITS - 1)) - (negative ? value_t'(0) : value_t'(1));
        if (!overflow)
        begin
            if (magnitude > (limit - d) / 10)
                overflow = 1'b1;
            else
                magnitude = magnitude * 10 + d;
        end
        bump_length();
    endtask

    task automatic add_letter(logic [7:0] c);
        for (int i = 0; i < KW_COUNT; i++)
            if (!(text_len < KW_LEN[i] && KW_TEXT[i][text_len[2:0]] == c))
                kw_live[i] = 1'b0;
        bump_length();
    endtask

    task automatic flush_token();
        logic [4:0] kind;
        case (scan)
            SC_NUM:
                if (overflow)
                    emit(KIND_ERROR, ERR_RANGE, '0, text_len);
                else
                    emit(KIND_NUMBER, ERR_NONE,
                         negative ? value_t'(0) - magnitude : magnitude, text_len);
            SC_IDENT:
            begin
                kind = KIND_IDENT;
                for (int i = 0; i < KW_COUNT; i++)
                    if (kw_live[i] && text_len == KW_LEN[i])
                        kind = KIND_INT + 5'(i);
                emit(kind, ERR_NONE, '0, text_len);
            end
            SC_MINUS:   emit(KIND_MINUS, ERR_NONE, '0, length_t'(1));
            SC_SLASH:   emit(KIND_SLASH, ERR_NONE, '0, length_t'(1));
            SC_EQ:      emit(KIND_ASSIGN, ERR_NONE, '0, length_t'(1));
            SC_NOT:     emit(KIND_NOT, ERR_NONE, '0, length_t'(1));
            SC_LT:      emit(KIND_LT, ERR_NONE, '0, length_t'(1));
            SC_GT:      emit(KIND_GT, ERR_NONE, '0, length_t'(1));
            SC_AND:     emit(KIND_ERROR, ERR_AMP, '0, length_t'(1));
            SC_OR:      emit(KIND_ERROR, ERR_BAR, '0, length_t'(1));
            SC_BRACKET: emit(KIND_BRACKET, ERR_NONE, '0, text_len);
            default: ;
        endcase
        scan = SC_START;
    endtask

    task automatic start_char(logic [7:0] c);
        if (is_digit(c))
        begin
            open_token(SC_NUM);
            text_len = '0;
            add_digit(c);
        end
        else if (is_word(c))
        begin
            open_token(SC_IDENT);
            text_len = '0;
            add_letter(c);
        end
        else if (c == CH_SPACE || c == CH_LF || c == CH_TAB || c == CH_CR)
            scan = SC_START;
        else
        begin
            open_token(SC_START);
            case (c)
                CH_PLUS:     emit(KIND_PLUS, ERR_NONE, '0, length_t'(1));
                CH_STAR:     emit(KIND_STAR, ERR_NONE, '0, length_t'(1));
                CH_PERCENT:  emit(KIND_PERCENT, ERR_NONE, '0, length_t'(1));
                CH_SEMI:     emit(KIND_SEMI, ERR_NONE, '0, length_t'(1));
                CH_LPAREN:   emit(KIND_LPAREN, ERR_NONE, '0, length_t'(1));
                CH_RPAREN:   emit(KIND_RPAREN, ERR_NONE, '0, length_t'(1));
                CH_LBRACE:   emit(KIND_LBRACE, ERR_NONE, '0, length_t'(1));
                CH_RBRACE:   emit(KIND_RBRACE, ERR_NONE, '0, length_t'(1));
                CH_COMMA:    emit(KIND_COMMA, ERR_NONE, '0, length_t'(1));
                CH_MINUS:    scan = SC_MINUS;
                CH_SLASH:    scan = SC_SLASH;
                CH_EQUAL:    scan = SC_EQ;
                CH_BANG:     scan = SC_NOT;
                CH_LESS:     scan = SC_LT;
                CH_GREATER:  scan = SC_GT;
                CH_AMP:      scan = SC_AND;
                CH_BAR:      scan = SC_OR;
                CH_LBRACKET: scan = SC_BRACKET;
                default:     emit(KIND_ERROR, ERR_CHAR, '0, length_t'(1));
            endcase
        end
    endtask

    task automatic pair_or_flush(logic [7:0] c, logic [7:0] want, logic [4:0] kind);
        if (c == want)
        begin
            emit(kind, ERR_NONE, '0, length_t'(2));
            scan = SC_START;
        end
        else
        begin
            flush_token();
            start_char(c);
        end
    endtask

    task automatic predict_tokens(char_item_t it);
        logic [7:0]  c;
        token_item_t t;
        c = it.char_code;
        char_tokens.delete();
        if (it.end_of_input)
        begin
            flush_token();
            emit(KIND_EOF, ERR_NONE, '0, '0);
            clear_scanner();
        end
        else
        begin
            case (scan)
                SC_NUM:
                    if (is_digit(c))
                        add_digit(c);
                    else
                    begin
                        flush_token();
                        start_char(c);
                    end
                SC_IDENT:
                    if (is_word(c))
                        add_letter(c);
                    else
                    begin
                        flush_token();
                        start_char(c);
                    end
                SC_MINUS:
                    if (is_digit(c))
                    begin
                        scan     = SC_NUM;
                        negative = 1'b1;
                        add_digit(c);
                    end
                    else
                    begin
                        flush_token();
                        start_char(c);
                    end
                SC_SLASH:
                    if (c == CH_SLASH)
                        scan = SC_LINE;
                    else if (c == CH_STAR)
                    begin
                        scan      = SC_BLOCK;
                        star_seen = 1'b0;
                    end
                    else
                    begin
                        flush_token();
                        start_char(c);
                    end
                SC_EQ:  pair_or_flush(c, CH_EQUAL, KIND_EQ);
                SC_NOT: pair_or_flush(c, CH_EQUAL, KIND_NE);
                SC_LT:  pair_or_flush(c, CH_EQUAL, KIND_LE);
                SC_GT:  pair_or_flush(c, CH_EQUAL, KIND_GE);
                SC_AND: pair_or_flush(c, CH_AMP, KIND_AND);
                SC_OR:  pair_or_flush(c, CH_BAR, KIND_OR);
                SC_LINE:
                    if (c == CH_LF)
                        scan = SC_START;
                SC_BLOCK:
                    if (star_seen && c == CH_SLASH)
                    begin
                        scan      = SC_START;
                        star_seen = 1'b0;
                    end
                    else
                        star_seen = (c == CH_STAR);
                SC_BRACKET:
                begin
                    bump_length();
                    if (c == CH_RBRACKET)
                    begin
                        emit(KIND_BRACKET, ERR_NONE, '0, text_len);
                        scan = SC_START;
                    end
                end
                default: start_char(c);
            endcase
        end
        foreach (char_tokens[i])
        begin
            t = {char_tokens[i], i == char_tokens.size() - 1};
            expected_tokens.push_back(t);
        end
    endtask

    task automatic check_token(token_item_t got);
        token_item_t want;
        if (expected_tokens.size() == 0)
        begin
            report_mismatch($sformatf("kind %0d length %0d with nothing expected",
                                      got.token_kind, got.token_length));
            return;
        end
        want = expected_tokens.pop_front();
        if (got.token_kind !== want.token_kind || got.error_code !== want.error_code
            || got.number_value !== want.number_value
            || got.token_length !== want.token_length
            || got.last_of_item !== want.last_of_item)
            report_mismatch($sformatf(
                "got kind %0d err %0d value %0d len %0d last %0b, want %0d %0d %0d %0d %0b",
                got.token_kind, got.error_code, got.number_value, got.token_length,
                got.last_of_item, want.token_kind, want.error_code, want.number_value,
                want.token_length, want.last_of_item));
    endtask

    // token side first: a token never stems from the byte taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_scanner();
            expected_tokens.delete();
            fail_count = 0;
        end
        else
        begin
            if (token_valid && !token_stall)
                check_token(token_item);
            if (char_valid && !char_stall)
                predict_tokens(char_item);
        end
        tokens_due = expected_tokens.size();
    end

endmodule

// File: bench/tb.sv
module tb;
    import sct_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_CHARS  = 40;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        char_valid  = 1'b0;
    logic        char_stall;
    char_item_t  char_item   = '0;
    logic        token_valid;
    logic        token_stall = 1'b0;
    token_item_t token_item;
    int          fail_count;
    int          tokens_due;
    int          idle_pct     = 0;
    int          stall_pct    = 0;
    int          chars_sent   = 0;
    int          quiet_cycles = 0;

    string keywords [KW_COUNT] = '{"int", "if", "else", "while", "print"};
    string operators [21] = '{"+", "-", "*", "/", "%", "=", "==", "!", "!=", "<", "<=",
                              ">", ">=", "&&", "||", ";", "(", ")", "{", "}", ","};

    always #5 clk = ~clk;

    source_code_tokenizer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_item   (char_item),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_item  (token_item)
    );

    tokenizer_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_item   (char_item),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_item  (token_item),
        .fail_count  (fail_count),
        .tokens_due  (tokens_due)
    );

    always @(posedge clk)
        token_stall <= ($urandom_range(0, 99) < stall_pct);

    // ends the run if neither channel moves a beat for too long
    always @(posedge clk)
    begin
        if ((char_valid && !char_stall) || (token_valid && !token_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_char(logic [7:0] c, logic eoi);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_item  <= '{char_code: c, end_of_input: eoi};
        do
            @(posedge clk);
        while (char_stall);
        chars_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
    endtask

    task automatic send_eoi();
        send_char(8'($urandom), 1'b1);
    endtask

    task automatic wait_drained();
        char_valid <= 1'b0;
        do
            @(negedge clk);
        while (tokens_due != 0);
        @(posedge clk);
    endtask

    function automatic logic [7:0] word_char();
        case ($urandom_range(0, 3))
            0:       return CH_LOWER_A + 8'($urandom_range(0, 25));
            1:       return CH_UPPER_A + 8'($urandom_range(0, 25));
            2:       return CH_0 + 8'($urandom_range(0, 9));
            default: return CH_UNDER;
        endcase
    endfunction

    // mostly well-formed tokens, with comments, brackets and some noise between
    task automatic send_random_token();
        int          pick;
        int          n;
        logic [63:0] v;
        logic [7:0]  b;
        string       s;
        pick = $urandom_range(0, 99);
        n    = $urandom_range(0, 6);
        if (pick < 16)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                s = keywords[$urandom_range(0, KW_COUNT - 1)];
                send_text(s.substr(0, $urandom_range(0, s.len() - 1)));
                if ($urandom_range(0, 3) == 0)
                    send_char(word_char(), 1'b0);
            end
            else
            begin
                send_char(($urandom_range(0, 4) == 0) ? CH_UNDER
                          : CH_UPPER_A + 8'($urandom_range(0, 25)), 1'b0);
                repeat (n)
                    send_char(word_char(), 1'b0);
            end
        end
        else if (pick < 32)
        begin
            if ($urandom_range(0, 2) == 0)
                send_char(CH_MINUS, 1'b0);
            v = {$urandom, $urandom};
            case ($urandom_range(0, 5))
                0:       s = $sformatf("%0d", $urandom_range(0, 999));
                1:       s = $sformatf("%0d", v);
                2:       s = $sformatf("%0d", v >> $urandom_range(1, 63));
                3:       s = "9223372036854775807";
                4:       s = $sformatf("922337203685477580%0d", $urandom_range(7, 9));
                default: s = "99999999999999999999";
            endcase
            send_text(s);
        end
        else if (pick < 55)
            send_text(operators[$urandom_range(0, 20)]);
        else if (pick < 62)
        begin
            case ($urandom_range(0, 3))
                0:       send_char(CH_SPACE, 1'b0);
                1:       send_char(CH_TAB, 1'b0);
                2:       send_char(CH_LF, 1'b0);
                default: send_char(CH_CR, 1'b0);
            endcase
        end
        else if (pick < 67)
        begin
            send_text("//");
            repeat (n)
            begin
                do
                    b = 8'($urandom);
                while (b == CH_LF);
                send_char(b, 1'b0);
            end
            send_char(CH_LF, 1'b0);
        end
        else if (pick < 72)
        begin
            send_text("/*");
            repeat (n)
            begin
                case ($urandom_range(0, 2))
                    0:       send_char(CH_STAR, 1'b0);
                    1:       send_char(CH_SLASH, 1'b0);
                    default: send_char(8'($urandom), 1'b0);
                endcase
            end
            send_text("*/");
        end
        else if (pick < 77)
        begin
            send_char(CH_LBRACKET, 1'b0);
            repeat (n)
            begin
                do
                    b = 8'($urandom);
                while (b == CH_RBRACKET);
                send_char(b, 1'b0);
            end
            send_char(CH_RBRACKET, 1'b0);
        end
        else if (pick < 82)
            send_char($urandom_range(0, 1) ? CH_AMP : CH_BAR, 1'b0);
        else if (pick < 92)
            send_char(8'($urandom), 1'b0);
        else if (pick < 95)
            send_eoi();
        else
            send_char(8'($urandom_range(33, 126)), 1'b0);
        if ($urandom_range(0, 1) == 0)
            send_char(CH_SPACE, 1'b0);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("int if else while print intx whil printf _A9z ");
        send_text("9223372036854775807 -9223372036854775808 9223372036854775808 ");
        send_text("-9223372036854775809 0 00042 -0 5-3 12ab ");
        send_text("+-*/%= == != ! < <= > >= && || ;(){},");
        send_text("a&b c|d && || & ");
        send_char(CH_CR, 1'b0);
        send_char(CH_TAB, 1'b0);
        // the opening star must not close the comment
        send_text("x//note\ny/*a**b*/z/*/ still open */ [two words]k ");
        send_char(8'h00, 1'b0);
        send_char(8'h40, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(8'hFF, 1'b0);
        send_eoi();
        // end of input with something pending
        send_text("[open");
        send_eoi();
        send_text("&");
        send_eoi();
        send_text("|");
        send_eoi();
        send_text("-");
        send_eoi();
        send_text("-7");
        send_eoi();
        send_text("<");
        send_eoi();
        send_text("/*x");
        send_eoi();
        send_text("//x");
        send_eoi();
        send_text("print");
        send_eoi();
        send_eoi();
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 86; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 86; end
                default: begin idle_pct = 29; stall_pct = 29; end
            endcase
            chars_sent = 0;
            while (chars_sent < PHASE_CHARS)
                send_random_token();
            send_eoi();
            // hold the sender until every token of the phase is out
            wait_drained();
        end

        idle_pct  = 0;
        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && tokens_due == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
